### hw/rtl/slid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list package
// Command, status and cell operation codes, and the control struct that is
// broadcast from the list controller to every cell of the chain.
// ----------------------------------------------------------------------------
package slid_pkg;

   // Command codes carried in req_tuser.
   localparam logic [1:0] CMD_INSERT  = 2'd0;
   localparam logic [1:0] CMD_DELETE  = 2'd1;
   localparam logic [1:0] CMD_READOUT = 2'd2;

   // Status codes carried in rsp_tuser.
   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_FULL      = 2'd1;
   localparam logic [1:0] STS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STS_EMPTY     = 2'd3;

   // Operations that a cell performs.
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_DELETE = 2'd2;
   localparam logic [1:0] CELL_ROTATE = 2'd3;

   localparam int VALUE_W = 32;

   // Control broadcast to all cells.
   typedef struct packed {
      logic [1:0]                op;
      logic signed [VALUE_W-1:0] operand;
   } cell_ctrl_type;

endpackage

### hw/rtl/slid_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list cell
// Holds one stored value and exchanges it with its neighbors on insert,
// delete and readout rotation.
// ----------------------------------------------------------------------------
module slid_cell (
   input  logic                                 clock,
   input  slid_pkg::cell_ctrl_type              ctrl,
   input  logic                                 valid,
   input  logic signed [slid_pkg::VALUE_W-1:0]  prev_value,
   input  logic                                 prev_greater,
   input  logic signed [slid_pkg::VALUE_W-1:0]  next_value,
   output logic signed [slid_pkg::VALUE_W-1:0]  value_o,
   output logic                                 greater,
   output logic                                 match
);

   logic signed [slid_pkg::VALUE_W-1:0] value_ff;
   logic signed [slid_pkg::VALUE_W-1:0] value_in;

   // For insert an empty cell counts as greater, so the new value lands at the
   // end of the list. For delete the flag marks cells at or past the match.
   always_comb begin
      if (ctrl.op == slid_pkg::CELL_INSERT) begin
         greater = !valid || (value_ff > ctrl.operand);
      end else begin
         greater = valid && (value_ff >= ctrl.operand);
      end
      match = valid && (value_ff == ctrl.operand);
   end

   // Next value from the neighbor exchange.
   always_comb begin
      case (ctrl.op)
         slid_pkg::CELL_INSERT: begin
            if (prev_greater) begin
               value_in = prev_value;
            end else if (greater) begin
               value_in = ctrl.operand;
            end else begin
               value_in = value_ff;
            end
         end
         slid_pkg::CELL_DELETE: begin
            value_in = greater ? next_value : value_ff;
         end
         slid_pkg::CELL_ROTATE: begin
            value_in = next_value;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_o = value_ff;

endmodule

### hw/rtl/sorted_list_insert_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list with insert, delete and readout
// Keeps up to CAPACITY signed values in ascending order in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_*) carries one command per beat: tuser holds the
//   command (insert, delete, readout) and tdata the signed value. The response
//   channel (rsp_*) returns a status in tuser, a value in tdata and tlast on
//   the final beat that a command causes.
//   Insert and delete update every cell in the cycle the request beat is
//   accepted, and the single response beat appears in the next cycle. The next
//   request is taken in the following cycle, so these commands run at one per
//   cycle while the response side keeps up.
//   A readout rotates the whole ring of cells once, one position per cycle while
//   no stall holds it; the first N rotation steps (N stored values) each send
//   one response beat. Requests wait until the rotation is complete. An empty
//   readout gives one beat with status empty.
//   Unused command code 3 is accepted and dropped without a response.
//   Reset empties the list; cell contents are not cleared.
//   When the receiver stalls, the response register holds its beat; requests
//   and the rotation step that sends the next readout beat wait until it is
//   taken.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] out_value
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic                                state_ff, state_in;
   logic [CW-1:0]                       count_ff, count_in;
   logic [CW-1:0]                       step_ff, step_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [1:0]                          rsp_status_ff, rsp_status_in;
   logic signed [slid_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                                rsp_last_ff, rsp_last_in;

   slid_pkg::cell_ctrl_type             ctrl;
   logic signed [slid_pkg::VALUE_W-1:0] cell_value [CAPACITY];
   logic [CAPACITY-1:0]                 cell_greater;
   logic [CAPACITY-1:0]                 cell_match;

   logic                                slot_free;
   logic                                accept;
   logic                                full;
   logic                                found;
   logic                                emitting;
   logic signed [slid_pkg::VALUE_W-1:0] req_value;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;
   assign req_value  = signed'(req_tdata);
   assign full       = (count_ff == CW'(CAPACITY));
   assign found      = |cell_match;
   assign emitting   = (step_ff < count_ff);

   // Cell chain. The last cell's right neighbor is the first cell, closing the
   // ring used for readout.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [slid_pkg::VALUE_W-1:0] prev_v;
      logic                                prev_g;
      logic signed [slid_pkg::VALUE_W-1:0] next_v;

      if (i == 0) begin : g_first
         assign prev_v = '0;
         assign prev_g = 1'b0;
      end else begin : g_mid
         assign prev_v = cell_value[i-1];
         assign prev_g = cell_greater[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_v = cell_value[0];
      end else begin : g_inner
         assign next_v = cell_value[i+1];
      end

      slid_cell u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .valid        (CW'(i) < count_ff),
         .prev_value   (prev_v),
         .prev_greater (prev_g),
         .next_value   (next_v),
         .value_o      (cell_value[i]),
         .greater      (cell_greater[i]),
         .match        (cell_match[i])
      );
   end

   // Controller: picks the cell operation and loads the response register.
   always_comb begin
      ctrl.op       = slid_pkg::CELL_HOLD;
      ctrl.operand  = req_value;
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  slid_pkg::CMD_INSERT: begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = req_value;
                     rsp_last_in  = 1'b1;
                     if (full) begin
                        rsp_status_in = slid_pkg::STS_FULL;
                     end else begin
                        rsp_status_in = slid_pkg::STS_OK;
                        ctrl.op       = slid_pkg::CELL_INSERT;
                        count_in      = count_ff + CW'(1);
                     end
                  end
                  slid_pkg::CMD_DELETE: begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = req_value;
                     rsp_last_in  = 1'b1;
                     if (found) begin
                        rsp_status_in = slid_pkg::STS_OK;
                        ctrl.op       = slid_pkg::CELL_DELETE;
                        count_in      = count_ff - CW'(1);
                     end else begin
                        rsp_status_in = slid_pkg::STS_NOT_FOUND;
                     end
                  end
                  slid_pkg::CMD_READOUT: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = slid_pkg::STS_EMPTY;
                        rsp_value_in  = '0;
                        rsp_last_in   = 1'b1;
                     end else begin
                        state_in = ST_READ;
                        step_in  = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            // Rotate one position; the head cell's value goes out while the
            // step is still inside the stored part of the list.
            if (!emitting || slot_free) begin
               ctrl.op = slid_pkg::CELL_ROTATE;
               if (emitting) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = slid_pkg::STS_OK;
                  rsp_value_in  = cell_value[0];
                  rsp_last_in   = (step_ff == count_ff - CW'(1));
               end
               if (step_ff == CW'(CAPACITY - 1)) begin
                  step_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  step_in = step_ff + CW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload needs no reset.
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // The fill count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("list count exceeds capacity");

   // An insert into a list that is not full adds exactly one entry.
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == slid_pkg::CMD_INSERT && !full)
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the list by one");

   // The list size stays fixed during a readout rotation.
   a_read_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> count_ff == $past(count_ff))
      else $error("list size changed during readout");

   // The step counter rests at zero whenever no readout is running.
   a_step_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> step_ff == '0)
      else $error("readout step counter not cleared");
`endif

endmodule

### tb/sorted_list_insert_delete_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list insert/delete testbench
// Drives insert, delete and readout commands into the sorted list. It keeps
// its own ordered copy of the list to predict every response beat, and it
// checks each beat field by field. The sender and the receiver pause in
// random bursts, except during the final stretch of traffic.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete_tb;

   localparam int CAPACITY = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;

   // Command code 3 is not defined by the block and must be dropped silently.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // One response beat as the list should produce it.
   typedef struct {
      logic [1:0]  status;
      logic [31:0] value;
      logic        last;
   } list_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // [31:0] value
   logic [1:0]  req_tuser = '0;    // [1:0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [31:0] out_value
   logic [1:0]  rsp_tuser;         // [1:0] status
   logic        rsp_tlast;

   // Ordered copy of the list contents and the beats still owed by the block.
   logic signed [31:0] stored_values[$];
   list_beat_type      pending_beats[$];
   list_beat_type      oldest_beat;

   int error_count = 0;
   int cycle_count = 0;
   bit idle_on = 1'b1;

   sorted_list_insert_delete #(
      .CAPACITY(CAPACITY)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d beats outstanding", $time, pending_beats.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic void push_beat(input logic [1:0] status, input logic [31:0] value,
                                     input logic last);
      list_beat_type b;
      b.status = status;
      b.value  = value;
      b.last   = last;
      pending_beats.push_back(b);
   endfunction

   // Applies one accepted command to the list copy and queues its beats.
   function automatic void predict_command(input logic [1:0] cmd,
                                           input logic signed [31:0] val);
      int pos;
      int i;
      pos = -1;
      case (cmd)
         slid_pkg::CMD_INSERT: begin
            if (stored_values.size() >= CAPACITY) begin
               push_beat(slid_pkg::STS_FULL, val, 1'b1);
            end else begin
               // Equal values stay in arrival order: stop at the first greater one.
               pos = stored_values.size();
               for (i = 0; i < stored_values.size(); i++) begin
                  if (stored_values[i] > val) begin
                     pos = i;
                     break;
                  end
               end
               stored_values.insert(pos, val);
               push_beat(slid_pkg::STS_OK, val, 1'b1);
            end
         end
         slid_pkg::CMD_DELETE: begin
            for (i = 0; i < stored_values.size(); i++) begin
               if (stored_values[i] == val) begin
                  pos = i;
                  break;
               end
            end
            if (pos < 0) begin
               push_beat(slid_pkg::STS_NOT_FOUND, val, 1'b1);
            end else begin
               stored_values.delete(pos);
               push_beat(slid_pkg::STS_OK, val, 1'b1);
            end
         end
         slid_pkg::CMD_READOUT: begin
            if (stored_values.size() == 0) begin
               push_beat(slid_pkg::STS_EMPTY, 32'd0, 1'b1);
            end else begin
               for (i = 0; i < stored_values.size(); i++)
                  push_beat(slid_pkg::STS_OK, stored_values[i],
                            i == stored_values.size() - 1);
            end
         end
         default: begin
            // Unused code: no beat and no change.
         end
      endcase
   endfunction

   // Sends one request beat. Called at a falling edge; returns at the falling
   // edge after acceptance with tvalid still high, so back-to-back beats
   // never see tvalid dropped and raised in the same step.
   task automatic send_item(input logic [1:0] cmd, input logic [31:0] val);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= val;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_command(cmd, val);
      @(negedge clock);
   endtask

   // Values lean toward a small pool and the extremes so that duplicates,
   // hits on delete and signed ordering across zero all occur often.
   function automatic logic [31:0] pick_value();
      int roll;
      logic [31:0] v;
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
         v = $urandom_range(0, 8) - 4;
      end else if (roll < 55) begin
         case ($urandom_range(0, 5))
            0: v = 32'h8000_0000;
            1: v = 32'h8000_0001;
            2: v = 32'h7FFF_FFFF;
            3: v = 32'h7FFF_FFFE;
            4: v = 32'h0000_0000;
            default: v = 32'hFFFF_FFFF;
         endcase
      end else begin
         v = $urandom;
      end
      return v;
   endfunction

   // Most deletes target a value that is actually stored.
   function automatic logic [31:0] pick_delete_value();
      logic [31:0] v;
      if (stored_values.size() != 0 && $urandom_range(0, 9) < 7)
         v = stored_values[$urandom_range(0, stored_values.size() - 1)];
      else
         v = pick_value();
      return v;
   endfunction

   // Response side: random stall bursts while idling is enabled.
   initial begin
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (idle_on && !reset && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compares every accepted response beat with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_beats.size() == 0) begin
            $display("%0t: unexpected beat, expected none, got status %0d value %h last %b",
                     $time, rsp_tuser, rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            oldest_beat = pending_beats.pop_front();
            if (rsp_tuser !== oldest_beat.status) begin
               $display("%0t: status mismatch, expected %0d, got %0d",
                        $time, oldest_beat.status, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata !== oldest_beat.value) begin
               $display("%0t: value mismatch, expected %h, got %h",
                        $time, oldest_beat.value, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== oldest_beat.last) begin
               $display("%0t: last mismatch, expected %b, got %b",
                        $time, oldest_beat.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // Readout and delete on an empty list, and the unused command code.
   task automatic test_empty_list();
      send_item(slid_pkg::CMD_READOUT, 32'h0000_0000);
      send_item(slid_pkg::CMD_DELETE, 32'h0000_0000);
      send_item(CMD_UNUSED, 32'hFFFF_FFFF);
   endtask

   // Signed extremes, a duplicate, a missed delete and a readout.
   task automatic test_extreme_values();
      send_item(slid_pkg::CMD_INSERT, 32'h7FFF_FFFF);
      send_item(slid_pkg::CMD_INSERT, 32'h8000_0000);
      send_item(slid_pkg::CMD_INSERT, 32'h0000_0000);
      send_item(slid_pkg::CMD_INSERT, 32'hFFFF_FFFF);
      send_item(slid_pkg::CMD_INSERT, 32'h0000_0000);
      send_item(slid_pkg::CMD_DELETE, 32'h0000_0005);
      send_item(slid_pkg::CMD_DELETE, 32'h0000_0000);
      send_item(slid_pkg::CMD_READOUT, 32'hFFFF_FFFF);
   endtask

   // Fills the list to capacity, then an insert into the full list and a
   // readout of all entries.
   task automatic test_full_list();
      while (stored_values.size() < CAPACITY)
         send_item(slid_pkg::CMD_INSERT, pick_value());
      send_item(slid_pkg::CMD_INSERT, 32'h0000_0001);
      send_item(slid_pkg::CMD_READOUT, 32'h0000_0000);
   endtask

   // One phase of random commands with the given mix; unused codes are
   // sprinkled in but not counted.
   task automatic run_random_phase(input int n_items, input int insert_pct,
                                   input int delete_pct);
      int done;
      int roll;
      done = 0;
      while (done < n_items) begin
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            send_item(CMD_UNUSED, $urandom);
         end else begin
            if (roll < 3 + insert_pct)
               send_item(slid_pkg::CMD_INSERT, pick_value());
            else if (roll < 3 + insert_pct + delete_pct)
               send_item(slid_pkg::CMD_DELETE, pick_delete_value());
            else
               send_item(slid_pkg::CMD_READOUT, $urandom);
            done++;
         end
      end
   endtask

   // Random traffic that swings the list between full and empty; the last
   // phase runs with no idling on either side.
   task automatic test_random_traffic();
      run_random_phase(105, 62, 23);
      run_random_phase(85, 20, 65);
      idle_on = 1'b0;
      run_random_phase(80, 45, 40);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_list();
      test_extreme_values();
      test_full_list();
      test_random_traffic();

      req_tvalid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_beats.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
